@@ rtl/tdm_pkg.sv @@
// Shared definitions for the table-driven DFA matcher core.
// Command and verdict codes, configuration indexes, field widths, match type.
// No dependencies.
package tdm_pkg;

  // Field widths of the input and result transactions
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned STATE_W = 6;
  localparam int unsigned TGT_W   = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VERD_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Slots addressable by the 4-bit slot field
  localparam int unsigned SLOT_LIMIT = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALPHA = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FINAL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TRANS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd4;

  // Verdict / reject codes
  localparam logic [VERD_W-1:0] RJ_NONE     = 2'd0;
  localparam logic [VERD_W-1:0] RJ_SYMBOL   = 2'd1;
  localparam logic [VERD_W-1:0] RJ_NOTRANS  = 2'd2;
  localparam logic [VERD_W-1:0] RJ_NOTFINAL = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMCNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINCNT  = 2'd2;

  // Result of the alphabet lookup
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] col;
  } sym_match_t;

endpackage

@@ rtl/table_driven_dfa_matcher_core.sv @@
// Top level of the table-driven DFA matcher.
// Depends on tdm_pkg, tdm_alphabet and tdm_final_list.
//
// Programmable deterministic finite automaton fed by one command stream.
// Write commands load the alphabet slots, the final-state list and the
// transition table (MAX_STATES x MAX_SYMBOLS entries in an on-chip RAM);
// entries must be written before they are used. Word-character commands
// map the byte to the lowest in-use alphabet slot and step the state
// through the transition table; a missing symbol or a negative target
// rejects the word until its end. An end-of-word command emits one result
// transaction (accepted, verdict, end_state) and rearms at start_state.
// Throughput is one input transaction per clock unless an end-of-word stalls.
// An accepted transaction lands in an input register; the alphabet match
// and the RAM read issue from there, and the RAM read data is folded into
// the state on the next cycle, so the state -> RAM address -> read data
// loop closes through rd_q. Results sit in an output register; the input
// only stalls when an end-of-word finds that register still full and not
// being taken. Configuration must be written while the core is idle.
module table_driven_dfa_matcher_core #(
  parameter int unsigned MAX_STATES  = 64,
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned MAX_FINALS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [tdm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tdm_pkg::COUNT_W:0]           cfg_wdata_i,
  // Command stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] command, [6:3] slot, [12:7] row_state, [19:13] target_state,
  // [25:20] final_state_value, [33:26] char_code, [39:34] zero
  input  logic [39:0]                         s_axis_tdata,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] accepted, [2:1] verdict, [8:3] end_state, [15:9] zero
  output logic [15:0]                         m_axis_tdata
);

  localparam int unsigned ASLOTS = (MAX_SYMBOLS < tdm_pkg::SLOT_LIMIT) ?
                                   MAX_SYMBOLS : tdm_pkg::SLOT_LIMIT;
  localparam int unsigned FSLOTS = (MAX_FINALS < tdm_pkg::SLOT_LIMIT) ?
                                   MAX_FINALS : tdm_pkg::SLOT_LIMIT;
  localparam int unsigned DEPTH  = MAX_STATES * MAX_SYMBOLS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [tdm_pkg::STATE_W-1:0] start_q;
  logic [tdm_pkg::COUNT_W-1:0] symcnt_q;
  logic [tdm_pkg::COUNT_W-1:0] fincnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      symcnt_q <= '0;
      fincnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tdm_pkg::CFG_START:  start_q  <= cfg_wdata_i[tdm_pkg::STATE_W-1:0];
        tdm_pkg::CFG_SYMCNT: symcnt_q <= cfg_wdata_i[tdm_pkg::COUNT_W-1:0];
        tdm_pkg::CFG_FINCNT: fincnt_q <= cfg_wdata_i[tdm_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                               in_vld_q;
  logic [tdm_pkg::CMD_W-1:0]          cmd_q;
  logic [tdm_pkg::SLOT_W-1:0]         slot_q;
  logic [tdm_pkg::STATE_W-1:0]        row_q;
  logic signed [tdm_pkg::TGT_W-1:0]   tgt_q;
  logic [tdm_pkg::STATE_W-1:0]        fval_q;
  logic [tdm_pkg::CHAR_W-1:0]         char_q;

  logic s_fire;    // transaction taken from the command stream
  logic a_fire;    // registered command executes this cycle
  logic out_free;  // result register can take a new result

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign a_fire        = in_vld_q && ((cmd_q != tdm_pkg::CMD_END) || out_free);
  assign s_axis_tready = !in_vld_q || a_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (a_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q  <= s_axis_tdata[2:0];
      slot_q <= s_axis_tdata[6:3];
      row_q  <= s_axis_tdata[12:7];
      tgt_q  <= s_axis_tdata[19:13];
      fval_q <= s_axis_tdata[25:20];
      char_q <= s_axis_tdata[33:26];
    end
  end

  // ---------------------------------------------------------------------
  // Alphabet and final list
  // ---------------------------------------------------------------------
  tdm_pkg::sym_match_t         sym_match;
  logic                        is_final;
  logic [tdm_pkg::STATE_W-1:0] cur_b;

  tdm_alphabet #(
    .NUM_SLOTS (ASLOTS)
  ) u_alphabet (
    .clk_i          (clk_i),
    .we_i           (a_fire && (cmd_q == tdm_pkg::CMD_ALPHA)),
    .wslot_i        (slot_q),
    .wdata_i        (char_q),
    .symbol_count_i (symcnt_q),
    .char_i         (char_q),
    .match_o        (sym_match)
  );

  tdm_final_list #(
    .NUM_SLOTS (FSLOTS)
  ) u_final_list (
    .clk_i         (clk_i),
    .we_i          (a_fire && (cmd_q == tdm_pkg::CMD_FINAL) &&
                    (32'(slot_q) < MAX_FINALS)),
    .wslot_i       (slot_q),
    .wdata_i       (fval_q),
    .final_count_i (fincnt_q),
    .state_i       (cur_b),
    .is_final_o    (is_final)
  );

  // ---------------------------------------------------------------------
  // Word state; a transition read in flight resolves in the cycle after it issues
  // ---------------------------------------------------------------------
  logic [tdm_pkg::STATE_W-1:0] cur_q, cur_d, cur_e;
  logic [tdm_pkg::VERD_W-1:0]  rej_q, rej_d, rej_e, rej_b;
  logic                        started_q, started_d;
  logic                        pend_q, pend_d;
  logic [tdm_pkg::TGT_W-1:0]   rd_q;

  // Fold the pending read: negative target rejects, state holds
  assign cur_e = (pend_q && !rd_q[tdm_pkg::TGT_W-1]) ? rd_q[tdm_pkg::STATE_W-1:0] : cur_q;
  assign rej_e = (pend_q && rd_q[tdm_pkg::TGT_W-1]) ? tdm_pkg::RJ_NOTRANS : rej_q;

  // First command of a word starts from start_state
  assign cur_b = started_q ? cur_e : start_q;
  assign rej_b = started_q ? rej_e : tdm_pkg::RJ_NONE;

  logic state_ok;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr, ram_addr;

  assign state_ok = 32'(cur_b) < MAX_STATES;
  assign rd_en    = a_fire && (cmd_q == tdm_pkg::CMD_CHAR) &&
                    (rej_b == tdm_pkg::RJ_NONE) && sym_match.found && state_ok;
  assign wr_en    = a_fire && (cmd_q == tdm_pkg::CMD_TRANS) &&
                    (32'(row_q) < MAX_STATES) && (32'(slot_q) < MAX_SYMBOLS);
  assign rd_addr  = AW'(AW'(cur_b) * AW'(MAX_SYMBOLS) + AW'(sym_match.col));
  assign wr_addr  = AW'(AW'(row_q) * AW'(MAX_SYMBOLS) + AW'(slot_q));
  assign ram_addr = wr_en ? wr_addr : rd_addr;

  always_comb begin
    cur_d     = cur_e;
    rej_d     = rej_e;
    started_d = started_q;
    pend_d    = 1'b0;
    if (a_fire) begin
      case (cmd_q)
        tdm_pkg::CMD_CHAR: begin
          cur_d     = cur_b;
          rej_d     = rej_b;
          started_d = 1'b1;
          if (rej_b == tdm_pkg::RJ_NONE) begin
            if (!sym_match.found) begin
              rej_d = tdm_pkg::RJ_SYMBOL;
            end else if (!state_ok) begin
              rej_d = tdm_pkg::RJ_NOTRANS;
            end else begin
              pend_d = 1'b1;
            end
          end
        end
        tdm_pkg::CMD_END: begin
          cur_d     = cur_b;
          rej_d     = tdm_pkg::RJ_NONE;
          started_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      rej_q     <= tdm_pkg::RJ_NONE;
      started_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      rej_q     <= rej_d;
      started_q <= started_d;
      pend_q    <= pend_d;
    end
  end

  // Transition table RAM, one access per cycle, registered read
  logic [tdm_pkg::TGT_W-1:0] trans_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      trans_mem[ram_addr] <= tgt_q;
    end
    if (rd_en) begin
      rd_q <= trans_mem[ram_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic                        end_fire;
  logic [tdm_pkg::VERD_W-1:0]  verdict;
  logic                        out_vld_q;
  logic                        acc_q;
  logic [tdm_pkg::VERD_W-1:0]  verd_q;
  logic [tdm_pkg::STATE_W-1:0] end_state_q;

  assign end_fire = a_fire && (cmd_q == tdm_pkg::CMD_END);
  assign verdict  = ((rej_b == tdm_pkg::RJ_NONE) && !is_final) ?
                    tdm_pkg::RJ_NOTFINAL : rej_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (end_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      acc_q       <= (verdict == tdm_pkg::RJ_NONE);
      verd_q      <= verdict;
      end_state_q <= cur_b;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, end_state_q, verd_q, acc_q};

`ifndef NO_ASSERTIONS
  // A read in flight only exists inside a live, unrejected word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (started_q && (rej_q == tdm_pkg::RJ_NONE)))
    else $error("transition read pending outside a live word");

  // Never look up a row beyond the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(cur_b) < MAX_STATES))
    else $error("transition read with state out of range");

  // A held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !end_fire)
    else $error("result register overwritten while stalled");

  // The accept flag agrees with the verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (acc_q == (verd_q == tdm_pkg::RJ_NONE)))
    else $error("accepted flag disagrees with verdict");

  // The RAM never sees a read and a write in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("transition RAM read and write collide");
`endif

endmodule

@@ rtl/tdm_alphabet.sv @@
// Alphabet table of the DFA matcher: slot registers and lowest-slot match.
// Depends on tdm_pkg.
module tdm_alphabet #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [tdm_pkg::SLOT_W-1:0]      wslot_i,
  input  logic [tdm_pkg::CHAR_W-1:0]      wdata_i,
  input  logic [tdm_pkg::COUNT_W-1:0]     symbol_count_i,
  input  logic [tdm_pkg::CHAR_W-1:0]      char_i,
  output tdm_pkg::sym_match_t             match_o
);

  logic [tdm_pkg::CHAR_W-1:0] sym_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       hit;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (we_i && (wslot_i == tdm_pkg::SLOT_W'(i))) begin
        sym_q[i] <= wdata_i;
      end
    end
    assign hit[i] = (tdm_pkg::COUNT_W'(i) < symbol_count_i) && (sym_q[i] == char_i);
  end

  // Lowest matching slot wins
  always_comb begin
    match_o.found = |hit;
    match_o.col   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match_o.col = tdm_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

@@ rtl/tdm_final_list.sv @@
// Final-state list of the DFA matcher: slot registers and membership check.
// Depends on tdm_pkg.
module tdm_final_list #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [tdm_pkg::SLOT_W-1:0]      wslot_i,
  input  logic [tdm_pkg::STATE_W-1:0]     wdata_i,
  input  logic [tdm_pkg::COUNT_W-1:0]     final_count_i,
  input  logic [tdm_pkg::STATE_W-1:0]     state_i,
  output logic                            is_final_o
);

  logic [tdm_pkg::STATE_W-1:0] fin_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]        hit;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (we_i && (wslot_i == tdm_pkg::SLOT_W'(i))) begin
        fin_q[i] <= wdata_i;
      end
    end
    assign hit[i] = (tdm_pkg::COUNT_W'(i) < final_count_i) && (fin_q[i] == state_i);
  end

  assign is_final_o = |hit;

endmodule
